[hdl/clefia_gfn4_round_network_defines.svh]
// Assertion macros used by the round network RTL.
`ifndef CLEFIA_GFN4_ROUND_NETWORK_DEFINES_SVH
`define CLEFIA_GFN4_ROUND_NETWORK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CGFN4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CGFN4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cgfn4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cgfn4_pkg;

  // Default size of the round key store, in 32-bit words
  localparam int unsigned KEY_WORDS_DEF = 64;

  // Rounds less one after reset (128-bit key)
  localparam logic [4:0] RCM1_RESET = 5'd17;

  // Register index of round_count_minus_one
  localparam logic CFG_REG_ROUNDS = 1'b0;

  // Operation codes of an input transaction; code 3 is reserved
  typedef enum logic [1:0] {
    OP_KEY_WR  = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2
  } op_t;

  // Four 32-bit block words, element 0 is word 0
  typedef logic [3:0][31:0] blk_t;

  // Control of one pass through the round unit
  typedef struct packed {
    logic decrypt;   // rotate right instead of left
    logic last;      // final round, no rotation
  } rnd_ctl_t;

endpackage

`default_nettype wire

[hdl/cgfn4_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM: one write port, two read ports, registered read data
module cgfn4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

[hdl/cgfn4_round.sv]
`timescale 1ns / 1ps
`default_nettype none

// One GFN4 round: F0 on word 0, F1 on word 2, then the word rotation
module cgfn4_round (
  input  cgfn4_pkg::blk_t     blk_in,
  input  logic [31:0]         key0,
  input  logic [31:0]         key1,
  input  cgfn4_pkg::rnd_ctl_t ctl,
  output cgfn4_pkg::blk_t     blk_out
);

  import cgfn4_pkg::*;

  localparam logic [3:0] NIB_A [16] = '{4'he, 4'h6, 4'hc, 4'ha, 4'h8, 4'h7, 4'h2, 4'hf,
                                        4'hb, 4'h1, 4'h4, 4'h0, 4'h5, 4'h9, 4'hd, 4'h3};
  localparam logic [3:0] NIB_B [16] = '{4'h6, 4'h4, 4'h0, 4'hd, 4'h2, 4'hb, 4'ha, 4'h3,
                                        4'h9, 4'hc, 4'he, 4'hf, 4'h8, 4'h7, 4'h5, 4'h1};
  localparam logic [3:0] NIB_C [16] = '{4'hb, 4'h8, 4'h5, 4'he, 4'ha, 4'h6, 4'h4, 4'hc,
                                        4'hf, 4'h7, 4'h2, 4'h3, 4'h1, 4'h0, 4'hd, 4'h9};
  localparam logic [3:0] NIB_D [16] = '{4'ha, 4'h2, 4'h6, 4'hd, 4'h3, 4'h4, 4'h5, 4'he,
                                        4'h0, 4'h7, 4'h8, 4'h9, 4'hb, 4'hf, 4'hc, 4'h1};

  localparam logic [7:0] SBOX1 [256] = '{
    8'h6c,8'hda,8'hc3,8'he9,8'h4e,8'h9d,8'h0a,8'h3d,8'hb8,8'h36,8'hb4,8'h38,8'h13,8'h34,8'h0c,8'hd9,
    8'hbf,8'h74,8'h94,8'h8f,8'hb7,8'h9c,8'he5,8'hdc,8'h9e,8'h07,8'h49,8'h4f,8'h98,8'h2c,8'hb0,8'h93,
    8'h12,8'heb,8'hcd,8'hb3,8'h92,8'he7,8'h41,8'h60,8'he3,8'h21,8'h27,8'h3b,8'he6,8'h19,8'hd2,8'h0e,
    8'h91,8'h11,8'hc7,8'h3f,8'h2a,8'h8e,8'ha1,8'hbc,8'h2b,8'hc8,8'hc5,8'h0f,8'h5b,8'hf3,8'h87,8'h8b,
    8'hfb,8'hf5,8'hde,8'h20,8'hc6,8'ha7,8'h84,8'hce,8'hd8,8'h65,8'h51,8'hc9,8'ha4,8'hef,8'h43,8'h53,
    8'h25,8'h5d,8'h9b,8'h31,8'he8,8'h3e,8'h0d,8'hd7,8'h80,8'hff,8'h69,8'h8a,8'hba,8'h0b,8'h73,8'h5c,
    8'h6e,8'h54,8'h15,8'h62,8'hf6,8'h35,8'h30,8'h52,8'ha3,8'h16,8'hd3,8'h28,8'h32,8'hfa,8'haa,8'h5e,
    8'hcf,8'hea,8'hed,8'h78,8'h33,8'h58,8'h09,8'h7b,8'h63,8'hc0,8'hc1,8'h46,8'h1e,8'hdf,8'ha9,8'h99,
    8'h55,8'h04,8'hc4,8'h86,8'h39,8'h77,8'h82,8'hec,8'h40,8'h18,8'h90,8'h97,8'h59,8'hdd,8'h83,8'h1f,
    8'h9a,8'h37,8'h06,8'h24,8'h64,8'h7c,8'ha5,8'h56,8'h48,8'h08,8'h85,8'hd0,8'h61,8'h26,8'hca,8'h6f,
    8'h7e,8'h6a,8'hb6,8'h71,8'ha0,8'h70,8'h05,8'hd1,8'h45,8'h8c,8'h23,8'h1c,8'hf0,8'hee,8'h89,8'had,
    8'h7a,8'h4b,8'hc2,8'h2f,8'hdb,8'h5a,8'h4d,8'h76,8'h67,8'h17,8'h2d,8'hf4,8'hcb,8'hb1,8'h4a,8'ha8,
    8'hb5,8'h22,8'h47,8'h3a,8'hd5,8'h10,8'h4c,8'h72,8'hcc,8'h00,8'hf9,8'he0,8'hfd,8'he2,8'hfe,8'hae,
    8'hf8,8'h5f,8'hab,8'hf1,8'h1b,8'h42,8'h81,8'hd6,8'hbe,8'h44,8'h29,8'ha6,8'h57,8'hb9,8'haf,8'hf2,
    8'hd4,8'h75,8'h66,8'hbb,8'h68,8'h9f,8'h50,8'h02,8'h01,8'h3c,8'h7f,8'h8d,8'h1a,8'h88,8'hbd,8'hac,
    8'hf7,8'he4,8'h79,8'h96,8'ha2,8'hfc,8'h6d,8'hb2,8'h6b,8'h03,8'he1,8'h2e,8'h7d,8'h14,8'h95,8'h1d
  };

  // doubling in GF(2^4), z^4+z+1
  function automatic logic [3:0] nib_dbl(input logic [3:0] v);
    nib_dbl = {v[2:0], 1'b0} ^ (v[3] ? 4'h3 : 4'h0);
  endfunction

  // S0 built from the four nibble boxes
  function automatic logic [7:0] sbox0(input logic [7:0] x);
    logic [3:0] t0;
    logic [3:0] t1;
    logic [3:0] u0;
    logic [3:0] u1;
    t0 = NIB_A[x[7:4]];
    t1 = NIB_B[x[3:0]];
    u0 = t0 ^ nib_dbl(t1);
    u1 = nib_dbl(t0) ^ t1;
    sbox0 = {NIB_C[u0], NIB_D[u1]};
  endfunction

  // doubling in GF(2^8), 0x11d
  function automatic logic [7:0] dbl(input logic [7:0] v);
    logic [7:0] t;
    t = (v & 8'h80) != 8'h00 ? (v ^ 8'h0e) : v;
    dbl = {t[6:0], t[7]};
  endfunction

  function automatic logic [31:0] func0(input logic [31:0] v);
    logic [7:0] a, b, c, d, a2, b2, c2, d2, a4, b4, c4, d4;
    a  = sbox0(v[7:0]);
    b  = SBOX1[v[15:8]];
    c  = sbox0(v[23:16]);
    d  = SBOX1[v[31:24]];
    a2 = dbl(a);  b2 = dbl(b);  c2 = dbl(c);  d2 = dbl(d);
    a4 = dbl(a2); b4 = dbl(b2); c4 = dbl(c2); d4 = dbl(d2);
    func0 = {a4 ^ a2 ^ b4 ^ c2 ^ d,
             a4 ^ b4 ^ b2 ^ c ^ d2,
             a2 ^ b ^ c4 ^ c2 ^ d4,
             a ^ b2 ^ c4 ^ d4 ^ d2};
  endfunction

  function automatic logic [31:0] func1(input logic [31:0] v);
    logic [7:0] a, b, c, d, a2, b2, c2, d2, a8, b8, c8, d8;
    a  = SBOX1[v[7:0]];
    b  = sbox0(v[15:8]);
    c  = SBOX1[v[23:16]];
    d  = sbox0(v[31:24]);
    a2 = dbl(a); b2 = dbl(b); c2 = dbl(c); d2 = dbl(d);
    a8 = dbl(dbl(a2)); b8 = dbl(dbl(b2)); c8 = dbl(dbl(c2)); d8 = dbl(dbl(d2));
    func1 = {a8 ^ a2 ^ b2 ^ c8 ^ d,
             a2 ^ b8 ^ b2 ^ c ^ d8,
             a8 ^ b ^ c8 ^ c2 ^ d2,
             a ^ b8 ^ c2 ^ d8 ^ d2};
  endfunction

  logic [31:0] w1_mix;
  logic [31:0] w3_mix;

  // Feistel mixing of the odd words
  assign w1_mix = blk_in[1] ^ func0(blk_in[0] ^ key0);
  assign w3_mix = blk_in[3] ^ func1(blk_in[2] ^ key1);

  // word rotation, none after the final round
  always_comb begin
    if (ctl.last) begin
      blk_out = {w3_mix, blk_in[2], w1_mix, blk_in[0]};
    end else if (ctl.decrypt) begin
      blk_out = {blk_in[2], w1_mix, blk_in[0], w3_mix};
    end else begin
      blk_out = {blk_in[0], w3_mix, blk_in[2], w1_mix};
    end
  end

endmodule

`default_nettype wire

[hdl/clefia_gfn4_round_network.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  operation, key index/word, four block words
// out      output     out_valid/out_stall  four result block words
// cfg      input      APB psel/penable     round_count_minus_one at byte address 0
//
// A key write gives no result.
// An encrypt or decrypt runs R = round_count_minus_one + 1 rounds: one
// round per cycle through the single round unit, paced by the key store read.
// The finished block sits in an output register; the next transaction may be
// taken while it waits. Synchronous active-low reset; rounds reset to 18.
// The key store is not cleared by reset.

`include "clefia_gfn4_round_network_defines.svh"

module clefia_gfn4_round_network #(
  parameter int unsigned KEY_WORDS = cgfn4_pkg::KEY_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  input  logic [31:0] in_word2,
  input  logic [31:0] in_word3,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import cgfn4_pkg::*;

  localparam int unsigned AW = $clog2(KEY_WORDS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  rcm1_r;
  logic [4:0]  rnd_r, rnd_nxt;
  logic [4:0]  pair_r, pair_nxt;
  logic        dec_r, dec_nxt;
  blk_t        blk_r, blk_nxt;
  blk_t        blk_rnd;
  blk_t        out_blk_r;
  logic        out_valid_r;
  logic        in_acc;
  logic        acc_blk;
  logic        out_load;
  logic [4:0]  rd_pair;
  logic [4:0]  start_pair;
  logic        key_we;
  logic [31:0] key0, key1;
  rnd_ctl_t    rnd_ctl;
  logic [AW-1:0] key_mod [64];

  // word position modulo the store size, worked out at elaboration
  for (genvar g = 0; g < 64; g++) begin : g_mod
    localparam int unsigned MV = g % KEY_WORDS;
    assign key_mod[g] = AW'(MV);
  end

  // handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign acc_blk  = in_acc && (op_t'(in_operation) == OP_ENCRYPT ||
                               op_t'(in_operation) == OP_DECRYPT);
  assign key_we   = in_acc && op_t'(in_operation) == OP_KEY_WR &&
                    ({1'b0, in_key_index} < 7'(KEY_WORDS));

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcm1_r <= RCM1_RESET;
    end else if (psel && penable && pwrite && paddr[2] == CFG_REG_ROUNDS) begin
      rcm1_r <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == CFG_REG_ROUNDS) ? {27'd0, rcm1_r} : 32'd0;

  // key pair to fetch: first pair on accept, next pair while running
  assign start_pair = (op_t'(in_operation) == OP_DECRYPT) ? rcm1_r : 5'd0;
  assign rd_pair    = (state_r == ST_IDLE) ? start_pair
                    : (dec_r ? pair_r - 5'd1 : pair_r + 5'd1);

  cgfn4_ram #(
    .WIDTH (32),
    .DEPTH (KEY_WORDS)
  ) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .waddr   (in_key_index[AW-1:0]),
    .wdata   (in_key_word),
    .raddr_a (key_mod[{rd_pair, 1'b0}]),
    .raddr_b (key_mod[{rd_pair, 1'b1}]),
    .rdata_a (key0),
    .rdata_b (key1)
  );

  // shared round unit
  assign rnd_ctl.decrypt = dec_r;
  assign rnd_ctl.last    = (rnd_r == rcm1_r);

  cgfn4_round u_round (
    .blk_in  (blk_r),
    .key0    (key0),
    .key1    (key1),
    .ctl     (rnd_ctl),
    .blk_out (blk_rnd)
  );

  // output register is free when empty or being emptied
  assign out_load = (state_r == ST_FLUSH) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    pair_nxt  = pair_r;
    dec_nxt   = dec_r;
    blk_nxt   = blk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_blk) begin
          state_nxt = ST_RUN;
          rnd_nxt   = 5'd0;
          pair_nxt  = start_pair;
          dec_nxt   = (op_t'(in_operation) == OP_DECRYPT);
          blk_nxt   = {in_word3, in_word2, in_word1, in_word0};
        end
      end
      ST_RUN: begin
        blk_nxt  = blk_rnd;
        rnd_nxt  = rnd_r + 5'd1;
        pair_nxt = rd_pair;
        if (rnd_ctl.last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= 5'd0;
      pair_r  <= 5'd0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      pair_r  <= pair_nxt;
      dec_r   <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blk_r <= blk_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word0 = out_blk_r[0];
  assign out_word1 = out_blk_r[1];
  assign out_word2 = out_blk_r[2];
  assign out_word3 = out_blk_r[3];

  // checks
  `CGFN4_ASSERT_NOW(a_rnd_range, state_r == ST_RUN, rnd_r <= rcm1_r, "round count overran")
  `CGFN4_ASSERT_NOW(a_enc_pair, state_r == ST_RUN && !dec_r, pair_r == rnd_r, "encrypt pair off")
  `CGFN4_ASSERT_NOW(a_dec_pair, state_r == ST_RUN && dec_r, pair_r == rcm1_r - rnd_r, "decrypt pair off")
  `CGFN4_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(state_r) == ST_FLUSH, "result without block")
  `CGFN4_ASSERT_NEXT(a_start, acc_blk, state_r == ST_RUN && rnd_r == 5'd0, "block did not start")

endmodule

`default_nettype wire

[tb/tb_clefia_gfn4_round_network.sv]
`timescale 1ns / 1ps

module tb_clefia_gfn4_round_network;
  import cgfn4_pkg::*;

  // reserved operation code, ignored by the block
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_PER_PHASE = 285;

  // CLEFIA S0 nibble tables (input stage and output stage)
  localparam logic [3:0] SB0_HI [16] = '{'he, 'h6, 'hc, 'ha, 'h8, 'h7, 'h2, 'hf,
                                         'hb, 'h1, 'h4, 'h0, 'h5, 'h9, 'hd, 'h3};
  localparam logic [3:0] SB0_LO [16] = '{'h6, 'h4, 'h0, 'hd, 'h2, 'hb, 'ha, 'h3,
                                         'h9, 'hc, 'he, 'hf, 'h8, 'h7, 'h5, 'h1};
  localparam logic [3:0] SB0_OHI [16] = '{'hb, 'h8, 'h5, 'he, 'ha, 'h6, 'h4, 'hc,
                                          'hf, 'h7, 'h2, 'h3, 'h1, 'h0, 'hd, 'h9};
  localparam logic [3:0] SB0_OLO [16] = '{'ha, 'h2, 'h6, 'hd, 'h3, 'h4, 'h5, 'he,
                                          'h0, 'h7, 'h8, 'h9, 'hb, 'hf, 'hc, 'h1};

  // CLEFIA S1
  localparam logic [7:0] SBOX1 [256] = '{
    8'h6c, 8'hda, 8'hc3, 8'he9, 8'h4e, 8'h9d, 8'h0a, 8'h3d,
    8'hb8, 8'h36, 8'hb4, 8'h38, 8'h13, 8'h34, 8'h0c, 8'hd9,
    8'hbf, 8'h74, 8'h94, 8'h8f, 8'hb7, 8'h9c, 8'he5, 8'hdc,
    8'h9e, 8'h07, 8'h49, 8'h4f, 8'h98, 8'h2c, 8'hb0, 8'h93,
    8'h12, 8'heb, 8'hcd, 8'hb3, 8'h92, 8'he7, 8'h41, 8'h60,
    8'he3, 8'h21, 8'h27, 8'h3b, 8'he6, 8'h19, 8'hd2, 8'h0e,
    8'h91, 8'h11, 8'hc7, 8'h3f, 8'h2a, 8'h8e, 8'ha1, 8'hbc,
    8'h2b, 8'hc8, 8'hc5, 8'h0f, 8'h5b, 8'hf3, 8'h87, 8'h8b,
    8'hfb, 8'hf5, 8'hde, 8'h20, 8'hc6, 8'ha7, 8'h84, 8'hce,
    8'hd8, 8'h65, 8'h51, 8'hc9, 8'ha4, 8'hef, 8'h43, 8'h53,
    8'h25, 8'h5d, 8'h9b, 8'h31, 8'he8, 8'h3e, 8'h0d, 8'hd7,
    8'h80, 8'hff, 8'h69, 8'h8a, 8'hba, 8'h0b, 8'h73, 8'h5c,
    8'h6e, 8'h54, 8'h15, 8'h62, 8'hf6, 8'h35, 8'h30, 8'h52,
    8'ha3, 8'h16, 8'hd3, 8'h28, 8'h32, 8'hfa, 8'haa, 8'h5e,
    8'hcf, 8'hea, 8'hed, 8'h78, 8'h33, 8'h58, 8'h09, 8'h7b,
    8'h63, 8'hc0, 8'hc1, 8'h46, 8'h1e, 8'hdf, 8'ha9, 8'h99,
    8'h55, 8'h04, 8'hc4, 8'h86, 8'h39, 8'h77, 8'h82, 8'hec,
    8'h40, 8'h18, 8'h90, 8'h97, 8'h59, 8'hdd, 8'h83, 8'h1f,
    8'h9a, 8'h37, 8'h06, 8'h24, 8'h64, 8'h7c, 8'ha5, 8'h56,
    8'h48, 8'h08, 8'h85, 8'hd0, 8'h61, 8'h26, 8'hca, 8'h6f,
    8'h7e, 8'h6a, 8'hb6, 8'h71, 8'ha0, 8'h70, 8'h05, 8'hd1,
    8'h45, 8'h8c, 8'h23, 8'h1c, 8'hf0, 8'hee, 8'h89, 8'had,
    8'h7a, 8'h4b, 8'hc2, 8'h2f, 8'hdb, 8'h5a, 8'h4d, 8'h76,
    8'h67, 8'h17, 8'h2d, 8'hf4, 8'hcb, 8'hb1, 8'h4a, 8'ha8,
    8'hb5, 8'h22, 8'h47, 8'h3a, 8'hd5, 8'h10, 8'h4c, 8'h72,
    8'hcc, 8'h00, 8'hf9, 8'he0, 8'hfd, 8'he2, 8'hfe, 8'hae,
    8'hf8, 8'h5f, 8'hab, 8'hf1, 8'h1b, 8'h42, 8'h81, 8'hd6,
    8'hbe, 8'h44, 8'h29, 8'ha6, 8'h57, 8'hb9, 8'haf, 8'hf2,
    8'hd4, 8'h75, 8'h66, 8'hbb, 8'h68, 8'h9f, 8'h50, 8'h02,
    8'h01, 8'h3c, 8'h7f, 8'h8d, 8'h1a, 8'h88, 8'hbd, 8'hac,
    8'hf7, 8'he4, 8'h79, 8'h96, 8'ha2, 8'hfc, 8'h6d, 8'hb2,
    8'h6b, 8'h03, 8'he1, 8'h2e, 8'h7d, 8'h14, 8'h95, 8'h1d
  };

  // one input transaction
  typedef struct {
    logic [1:0]  op;
    logic [5:0]  key_index;
    logic [31:0] key_word;
    blk_t        blk;
  } gfn_txn_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [5:0]  in_key_index;
  logic [31:0] in_key_word;
  logic [31:0] in_word0, in_word1, in_word2, in_word3;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_word0, out_word1, out_word2, out_word3;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: own copy of the key store and the round setting
  logic [31:0] round_keys [KEY_WORDS_DEF];
  logic [4:0]  rounds_m1 = RCM1_RESET;

  gfn_txn_t    pending_txn_q [$];
  blk_t        expected_blk_q [$];
  int unsigned err_cnt = 0;

  gfn_txn_t    drv_txn;
  int unsigned drv_gap;
  int unsigned drv_burst;
  int unsigned stall_left;
  int unsigned stall_burst;
  int unsigned quiet_cycles;

  clefia_gfn4_round_network dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_key_word  (in_key_word),
    .in_word0     (in_word0),
    .in_word1     (in_word1),
    .in_word2     (in_word2),
    .in_word3     (in_word3),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word0    (out_word0),
    .out_word1    (out_word1),
    .out_word2    (out_word2),
    .out_word3    (out_word3),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------------

  // x2 in GF(2^4), z^4+z+1
  function automatic logic [3:0] gf16_x2(logic [3:0] v);
    return {v[2:0], 1'b0} ^ (v[3] ? 4'h3 : 4'h0);
  endfunction

  // x2 in GF(2^8), polynomial 0x11d
  function automatic logic [7:0] gf256_x2(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1d : 8'h00);
  endfunction

  function automatic logic [7:0] sbox0_byte(logic [7:0] x);
    logic [3:0] t0, t1, u0, u1;
    t0 = SB0_HI[x[7:4]];
    t1 = SB0_LO[x[3:0]];
    u0 = t0 ^ gf16_x2(t1);
    u1 = gf16_x2(t0) ^ t1;
    return {SB0_OHI[u0], SB0_OLO[u1]};
  endfunction

  function automatic logic [31:0] feistel_f0(logic [31:0] v);
    logic [7:0] a, b, c, d, a2, b2, c2, d2, a4, b4, c4, d4;
    a = sbox0_byte(v[7:0]);
    b = SBOX1[v[15:8]];
    c = sbox0_byte(v[23:16]);
    d = SBOX1[v[31:24]];
    a2 = gf256_x2(a); b2 = gf256_x2(b); c2 = gf256_x2(c); d2 = gf256_x2(d);
    a4 = gf256_x2(a2); b4 = gf256_x2(b2); c4 = gf256_x2(c2); d4 = gf256_x2(d2);
    return {a4 ^ a2 ^ b4 ^ c2 ^ d,
            a4 ^ b4 ^ b2 ^ c ^ d2,
            a2 ^ b ^ c4 ^ c2 ^ d4,
            a ^ b2 ^ c4 ^ d4 ^ d2};
  endfunction

  function automatic logic [31:0] feistel_f1(logic [31:0] v);
    logic [7:0] a, b, c, d, a2, b2, c2, d2, a8, b8, c8, d8;
    a = SBOX1[v[7:0]];
    b = sbox0_byte(v[15:8]);
    c = SBOX1[v[23:16]];
    d = sbox0_byte(v[31:24]);
    a2 = gf256_x2(a); b2 = gf256_x2(b); c2 = gf256_x2(c); d2 = gf256_x2(d);
    a8 = gf256_x2(gf256_x2(a2)); b8 = gf256_x2(gf256_x2(b2));
    c8 = gf256_x2(gf256_x2(c2)); d8 = gf256_x2(gf256_x2(d2));
    return {a8 ^ a2 ^ b2 ^ c8 ^ d,
            a2 ^ b8 ^ b2 ^ c ^ d8,
            a8 ^ b ^ c8 ^ c2 ^ d2,
            a ^ b8 ^ c2 ^ d8 ^ d2};
  endfunction

  // full GFN4 pass; decrypt walks the key pairs downwards and rotates right
  function automatic blk_t gfn4_rounds(blk_t b, logic decrypt);
    blk_t        w;
    int unsigned pair;
    w = b;
    for (int unsigned r = 0; r <= rounds_m1; r++) begin
      pair = decrypt ? rounds_m1 - r : r;
      w[1] ^= feistel_f0(w[0] ^ round_keys[(2 * pair) % KEY_WORDS_DEF]);
      w[3] ^= feistel_f1(w[2] ^ round_keys[(2 * pair + 1) % KEY_WORDS_DEF]);
      if (r < rounds_m1) begin
        if (decrypt) begin
          w = {w[2], w[1], w[0], w[3]};
        end else begin
          w = {w[0], w[3], w[2], w[1]};
        end
      end
    end
    return w;
  endfunction

  // update key copy or queue the expected block for one accepted transaction
  function automatic void apply_txn(gfn_txn_t t);
    case (t.op)
      OP_KEY_WR: begin
        if (t.key_index < KEY_WORDS_DEF) round_keys[t.key_index] = t.key_word;
      end
      OP_ENCRYPT: expected_blk_q.push_back(gfn4_rounds(t.blk, 1'b0));
      OP_DECRYPT: expected_blk_q.push_back(gfn4_rounds(t.blk, 1'b1));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hffff_ffff;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom();
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic gfn_txn_t make_txn(logic [1:0] op, logic [5:0] idx, logic [31:0] kw,
                                       logic [31:0] w0, logic [31:0] w1,
                                       logic [31:0] w2, logic [31:0] w3);
    gfn_txn_t t;
    t.op = op;
    t.key_index = idx;
    t.key_word = kw;
    t.blk = {w3, w2, w1, w0};
    return t;
  endfunction

  function automatic gfn_txn_t random_txn();
    int unsigned r;
    logic [1:0]  op;
    r = $urandom_range(0, 99);
    if (r < 42) op = OP_ENCRYPT;
    else if (r < 84) op = OP_DECRYPT;
    else if (r < 95) op = OP_KEY_WR;
    else op = OP_RESERVED;
    return make_txn(op, 6'($urandom_range(0, 63)), pick_word(),
                    pick_word(), pick_word(), pick_word(), pick_word());
  endfunction

  task automatic push_txn(gfn_txn_t t);
    pending_txn_q.push_back(t);
  endtask

  // everything sent and every result back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_txn_q.size() != 0 || in_valid || expected_blk_q.size() != 0);
  endtask

  // APB write of the round count, only ever issued with the block idle
  task automatic write_rounds(logic [4:0] v);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {CFG_REG_ROUNDS, 2'b00};
    pwdata  <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rounds_m1 = v;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s mismatch: expected %08h got %08h", $realtime, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction at a time from the pending queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
      drv_burst = 0;
    end else if (!(in_valid && in_stall)) begin
      // accepted at this edge
      if (in_valid) begin
        apply_txn(drv_txn);
        if (drv_burst > 0) begin
          drv_burst--;
          drv_gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          drv_burst = $urandom_range(20, 60);
          drv_gap = 0;
        end else begin
          drv_gap = ($urandom_range(0, 1) == 0) ? 0 : pick_idle();
        end
      end
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (pending_txn_q.size() != 0) begin
        drv_txn = pending_txn_q.pop_front();
        in_valid     <= 1'b1;
        in_operation <= drv_txn.op;
        in_key_index <= drv_txn.key_index;
        in_key_word  <= drv_txn.key_word;
        in_word0     <= drv_txn.blk[0];
        in_word1     <= drv_txn.blk[1];
        in_word2     <= drv_txn.blk[2];
        in_word3     <= drv_txn.blk[3];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results in order and applies back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    blk_t exp_blk;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      stall_burst = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blk_q.size() == 0) begin
          report_mismatch("unexpected result word0", 32'h0, out_word0);
        end else begin
          exp_blk = expected_blk_q.pop_front();
          if (out_word0 !== exp_blk[0]) report_mismatch("out_word0", exp_blk[0], out_word0);
          if (out_word1 !== exp_blk[1]) report_mismatch("out_word1", exp_blk[1], out_word1);
          if (out_word2 !== exp_blk[2]) report_mismatch("out_word2", exp_blk[2], out_word2);
          if (out_word3 !== exp_blk[3]) report_mismatch("out_word3", exp_blk[3], out_word3);
        end
      end
      // stall pattern, with stretches of none
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        stall_burst = $urandom_range(40, 120);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_idle() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on any port
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL clefia_gfn4_round_network");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [4:0] phase_rounds [6];
    logic [31:0] kw;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_KEY_WR;
    in_key_index <= 6'd0;
    in_key_word  <= 32'd0;
    in_word0     <= 32'd0;
    in_word1     <= 32'd0;
    in_word2     <= 32'd0;
    in_word3     <= 32'd0;
    out_stall    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'd0;
    phase_rounds = '{5'd0, 5'd31, 5'd21, 5'd25, 5'($urandom_range(1, 30)), RCM1_RESET};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the whole key store so that no round ever reads an unwritten word
    for (int i = 0; i < KEY_WORDS_DEF; i++) begin
      kw = (i % 8 == 0) ? 32'h0 : (i % 8 == 1) ? 32'hffff_ffff : $urandom();
      push_txn(make_txn(OP_KEY_WR, 6'(i), kw, $urandom(), $urandom(), $urandom(), $urandom()));
    end

    // directed: extreme blocks both ways, reserved code, key rewrites in use
    push_txn(make_txn(OP_ENCRYPT, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    push_txn(make_txn(OP_DECRYPT, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    push_txn(make_txn(OP_ENCRYPT, 6'd63, 32'hffff_ffff, '1, '1, '1, '1));
    push_txn(make_txn(OP_DECRYPT, 6'd63, 32'hffff_ffff, '1, '1, '1, '1));
    push_txn(make_txn(OP_ENCRYPT, 6'd0, 32'h0, 32'h5555_5555, 32'haaaa_aaaa,
                      32'h5555_5555, 32'haaaa_aaaa));
    push_txn(make_txn(OP_DECRYPT, 6'd0, 32'h0, 32'haaaa_aaaa, 32'h5555_5555,
                      32'haaaa_aaaa, 32'h5555_5555));
    push_txn(make_txn(OP_RESERVED, 6'd63, 32'hffff_ffff, '1, '1, '1, '1));
    push_txn(make_txn(OP_RESERVED, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    // key write with live-looking block words, which must be ignored
    push_txn(make_txn(OP_KEY_WR, 6'd0, 32'hffff_ffff, '1, '1, '1, '1));
    push_txn(make_txn(OP_ENCRYPT, 6'd0, 32'h0, 32'h0123_4567, 32'h89ab_cdef,
                      32'hfedc_ba98, 32'h7654_3210));
    push_txn(make_txn(OP_KEY_WR, 6'd1, 32'h0, '1, '1, '1, '1));
    push_txn(make_txn(OP_DECRYPT, 6'd0, 32'h0, 32'h0123_4567, 32'h89ab_cdef,
                      32'hfedc_ba98, 32'h7654_3210));
    push_txn(make_txn(OP_KEY_WR, 6'd63, 32'h8000_0001, 32'h0, 32'h0, 32'h0, 32'h0));
    push_txn(make_txn(OP_KEY_WR, 6'd35, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0));
    push_txn(make_txn(OP_ENCRYPT, 6'd0, 32'h0, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h1));
    push_txn(make_txn(OP_DECRYPT, 6'd0, 32'h0, 32'h1, 32'h8000_0000, 32'h1, 32'h8000_0000));

    // first phase runs with the reset round count
    for (int n = 0; n < RANDOM_PER_PHASE; n++) push_txn(random_txn());

    // further phases, each with a fresh round count written while idle
    foreach (phase_rounds[p]) begin
      wait_drained();
      write_rounds(phase_rounds[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) push_txn(random_txn());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS clefia_gfn4_round_network");
    end else begin
      $display("FAIL clefia_gfn4_round_network");
    end
    $finish;
  end

endmodule
